// ----- rtl/sscpt_pkg.sv -----
// ----------------------------------------------------------------------------
// sscpt_pkg
// Shared types and constants of the subarray sum counter with prefix table.
// ----------------------------------------------------------------------------
package sscpt_pkg;

  // Field widths
  localparam int VALUE_BITS = 16;
  localparam int SUM_BITS   = 32;
  localparam int COUNT_BITS = 20;
  localparam int SLOT_CNT_BITS = 11;

  // Default table depth (power of two: the home slot is the low bits of the hash)
  localparam int TABLE_SLOTS = 2048;

  // Epoch tag kept with every slot; tag zero is never a live epoch
  localparam int EPOCH_BITS = 8;

  // Multiplicative hash constant
  localparam logic [SUM_BITS-1:0] HASH_MULT = 32'h9E37_79B1;

  // Saturation limits
  localparam logic [COUNT_BITS-1:0]    COUNT_MAX    = '1;
  localparam logic [SLOT_CNT_BITS-1:0] SLOT_CNT_MAX = '1;

  // Register indexes
  localparam logic REG_TARGET_SUM = 1'b0;

  // One slot of the prefix table
  typedef struct packed {
    logic [EPOCH_BITS-1:0]    epoch;
    logic [SUM_BITS-1:0]      key;
    logic [SLOT_CNT_BITS-1:0] count;
  } slot_t;

  // Sequencer states
  typedef enum logic [6:0] {
    S_CLEAR = 7'b000_0001,
    S_SEED  = 7'b000_0010,
    S_IDLE  = 7'b000_0100,
    S_HASH  = 7'b000_1000,
    S_READ  = 7'b001_0000,
    S_CHECK = 7'b010_0000,
    S_DONE  = 7'b100_0000
  } state_t;

endpackage

// ----- rtl/subarray_sum_count_prefix_table_top.sv -----
// ----------------------------------------------------------------------------
// subarray_sum_count_prefix_table_top
// Counts contiguous runs of a signed sequence that sum to a target, using a
// linear-probed prefix-sum table in one synchronous memory.
// ----------------------------------------------------------------------------
// Each item runs S_HASH, then S_READ and S_CHECK per probe, for the lookup of
//   prefix minus target and then for the insert; S_DONE registers the result.
// Probes take turns on the single read port; a new item is taken only in
//   S_IDLE, after S_DONE finds the output free. A sequence end adds a seed write.
// Reset (rst, synchronous): clears control state, then a clearing pass over all
//   TABLE_SLOTS slots plus a seed write, again every 2^EPOCH_BITS-1 sequences.
// ----------------------------------------------------------------------------
module subarray_sum_count_prefix_table_top #(
  parameter int TABLE_SLOTS = sscpt_pkg::TABLE_SLOTS
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // configuration port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [2:0]                           paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready,
  // input channel
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [sscpt_pkg::VALUE_BITS-1:0]     value,
  input  logic                                 last,
  // output channel
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [sscpt_pkg::COUNT_BITS-1:0]     match_count,
  output logic                                 final_res,
  output logic                                 table_full
);

  localparam int SB = $clog2(TABLE_SLOTS);
  localparam int PB = SB + 1;
  localparam logic [PB-1:0] PROBE_LIMIT = PB'(TABLE_SLOTS);
  localparam logic [SB-1:0] LAST_SLOT   = SB'(TABLE_SLOTS - 1);
  localparam logic [SB-1:0] HASH_LOW    = sscpt_pkg::HASH_MULT[SB-1:0];
  localparam logic [sscpt_pkg::EPOCH_BITS-1:0] EPOCH_MAX = '1;
  localparam logic [sscpt_pkg::EPOCH_BITS-1:0] EPOCH_FIRST =
    sscpt_pkg::EPOCH_BITS'(1);

  sscpt_pkg::state_t state;

  logic [31:0]                             target_sum;
  logic [31:0]                             prefix_sum;
  logic [sscpt_pkg::COUNT_BITS-1:0]        running_count;
  logic                                    overflow_seen;
  logic [sscpt_pkg::EPOCH_BITS-1:0]        epoch;
  logic                                    last_r;
  logic                                    phase;
  logic [31:0]                             key_r;
  logic [SB-1:0]                           idx;
  logic [PB-1:0]                           probe_n;
  logic [SB-1:0]                           clr_idx;

  // memory ports
  logic                  wr_en;
  logic [SB-1:0]         wr_addr;
  sscpt_pkg::slot_t      wr_data;
  logic                  rd_en;
  sscpt_pkg::slot_t      rd_data;

  // configuration port
  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == sscpt_pkg::REG_TARGET_SUM) ? target_sum : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_sum <= 32'd0;
    end else if (cfg_wr && paddr[2] == sscpt_pkg::REG_TARGET_SUM) begin
      target_sum <= pwdata;
    end
  end

  // key selection and hashing (shared by both lookups)
  logic [31:0]   key_sel;
  logic [SB-1:0] home;
  assign key_sel = phase ? prefix_sum : (prefix_sum - target_sum);
  assign home    = SB'(key_sel[SB-1:0] * HASH_LOW);

  // probe result decode
  logic slot_live, slot_hit, slot_free, probes_done;
  assign slot_live   = (rd_data.epoch == epoch);
  assign slot_hit    = slot_live && (rd_data.key == key_r);
  assign slot_free   = !slot_live;
  assign probes_done = (probe_n == PROBE_LIMIT);

  // saturating adds
  logic [sscpt_pkg::COUNT_BITS:0]    count_sum;
  logic [sscpt_pkg::COUNT_BITS-1:0]  count_sat;
  logic [sscpt_pkg::SLOT_CNT_BITS-1:0] slot_inc;
  assign count_sum = {1'b0, running_count} +
                     (sscpt_pkg::COUNT_BITS + 1)'(rd_data.count);
  assign count_sat = count_sum[sscpt_pkg::COUNT_BITS] ? sscpt_pkg::COUNT_MAX
                   : count_sum[sscpt_pkg::COUNT_BITS-1:0];
  assign slot_inc  = (rd_data.count == sscpt_pkg::SLOT_CNT_MAX) ? rd_data.count
                   : rd_data.count + 1'b1;

  // handshakes
  logic out_free;
  assign in_ready = (state == sscpt_pkg::S_IDLE);
  assign out_free = !out_valid || out_ready;

  // memory write selection
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx;
    wr_data = '0;
    case (state)
      sscpt_pkg::S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_idx;
      end
      sscpt_pkg::S_SEED: begin
        // key zero always hashes to slot zero of an empty table
        wr_en         = 1'b1;
        wr_addr       = '0;
        wr_data.epoch = epoch;
        wr_data.key   = 32'd0;
        wr_data.count = sscpt_pkg::SLOT_CNT_BITS'(1);
      end
      sscpt_pkg::S_CHECK: begin
        wr_data.epoch = epoch;
        wr_data.key   = key_r;
        if (phase && slot_hit) begin
          wr_en         = 1'b1;
          wr_data.count = slot_inc;
        end else if (phase && slot_free) begin
          wr_en         = 1'b1;
          wr_data.count = sscpt_pkg::SLOT_CNT_BITS'(1);
        end
      end
      default: begin
      end
    endcase
  end

  assign rd_en = (state == sscpt_pkg::S_READ);

  sscpt_table #(
    .DEPTH (TABLE_SLOTS),
    .AW    (SB)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (idx),
    .rd_data (rd_data)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= sscpt_pkg::S_CLEAR;
      clr_idx       <= '0;
      epoch         <= EPOCH_FIRST;
      prefix_sum    <= 32'd0;
      running_count <= '0;
      overflow_seen <= 1'b0;
      phase         <= 1'b0;
      probe_n       <= '0;
    end else begin
      case (state)
        sscpt_pkg::S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == LAST_SLOT) begin
            state <= sscpt_pkg::S_SEED;
          end
        end
        sscpt_pkg::S_SEED: begin
          state <= sscpt_pkg::S_IDLE;
        end
        sscpt_pkg::S_IDLE: begin
          if (in_valid) begin
            prefix_sum <= prefix_sum +
              {{(32-sscpt_pkg::VALUE_BITS){value[sscpt_pkg::VALUE_BITS-1]}}, value};
            last_r     <= last;
            phase      <= 1'b0;
            state      <= sscpt_pkg::S_HASH;
          end
        end
        sscpt_pkg::S_HASH: begin
          key_r   <= key_sel;
          idx     <= home;
          probe_n <= '0;
          state   <= sscpt_pkg::S_READ;
        end
        sscpt_pkg::S_READ: begin
          probe_n <= probe_n + 1'b1;
          state   <= sscpt_pkg::S_CHECK;
        end
        sscpt_pkg::S_CHECK: begin
          if (!phase) begin
            // lookup of prefix minus target
            if (slot_hit) begin
              running_count <= count_sat;
            end
            if (slot_hit || slot_free || probes_done) begin
              phase <= 1'b1;
              state <= sscpt_pkg::S_HASH;
            end else begin
              idx   <= idx + 1'b1;
              state <= sscpt_pkg::S_READ;
            end
          end else begin
            // insert or increment the new prefix
            if (slot_hit || slot_free) begin
              state <= sscpt_pkg::S_DONE;
            end else if (probes_done) begin
              overflow_seen <= 1'b1;
              state         <= sscpt_pkg::S_DONE;
            end else begin
              idx   <= idx + 1'b1;
              state <= sscpt_pkg::S_READ;
            end
          end
        end
        sscpt_pkg::S_DONE: begin
          if (out_free) begin
            if (last_r) begin
              prefix_sum    <= 32'd0;
              running_count <= '0;
              overflow_seen <= 1'b0;
              if (epoch == EPOCH_MAX) begin
                epoch   <= EPOCH_FIRST;
                clr_idx <= '0;
                state   <= sscpt_pkg::S_CLEAR;
              end else begin
                epoch <= epoch + 1'b1;
                state <= sscpt_pkg::S_SEED;
              end
            end else begin
              state <= sscpt_pkg::S_IDLE;
            end
          end
        end
        default: begin
          state <= sscpt_pkg::S_IDLE;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == sscpt_pkg::S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == sscpt_pkg::S_DONE && out_free) begin
      match_count <= running_count;
      final_res   <= last_r;
      table_full  <= overflow_seen;
    end
  end

endmodule

// ----- rtl/sscpt_table.sv -----
// ----------------------------------------------------------------------------
// sscpt_table
// Prefix table storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module sscpt_table #(
  parameter int DEPTH = sscpt_pkg::TABLE_SLOTS,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic               clk,
  input  logic               wr_en,
  input  logic [AW-1:0]      wr_addr,
  input  sscpt_pkg::slot_t   wr_data,
  input  logic               rd_en,
  input  logic [AW-1:0]      rd_addr,
  output sscpt_pkg::slot_t   rd_data
);

  sscpt_pkg::slot_t mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, data registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- verif/subarray_sum_count_prefix_table_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// subarray_sum_count_prefix_table_top_tb
// Self-checking bench for the subarray sum counter. A scoreboard class keeps
// its own prefix-sum table and predicts every running count. Plain tasks drive
// the APB port and input channel, a receiver loop the output, with random gaps.
// ----------------------------------------------------------------------------
module subarray_sum_count_prefix_table_top_tb;

  localparam int VALUE_BITS    = sscpt_pkg::VALUE_BITS;
  localparam int SUM_BITS      = sscpt_pkg::SUM_BITS;
  localparam int COUNT_BITS    = sscpt_pkg::COUNT_BITS;
  localparam int SLOT_CNT_BITS = sscpt_pkg::SLOT_CNT_BITS;
  localparam int TABLE_SLOTS   = sscpt_pkg::TABLE_SLOTS;

  localparam int STALL_LIMIT = 100000;  // cycles with no transaction at all
  localparam int LONG_HOLD   = 600;     // receiver back-pressure stretch
  localparam int TAIL_CYCLES = 64;

  // Register addresses (byte address 4 * index)
  localparam logic [2:0] ADDR_TARGET_SUM = {sscpt_pkg::REG_TARGET_SUM, 2'b00};
  localparam logic [2:0] ADDR_UNUSED     = 3'd4;

  typedef struct packed {
    logic [COUNT_BITS-1:0] match_count;
    logic                  final_res;
    logic                  table_full;
  } count_result_t;

  typedef enum int {MIX_SMALL, MIX_FULL, MIX_STRIDE, MIX_EXTREME} value_mix_t;

  // --------------------------------------------------------------------------
  // Scoreboard: prefix table predictor plus queue of expected counts
  // --------------------------------------------------------------------------
  class match_count_board;
    logic [SUM_BITS-1:0]      target;
    logic [SUM_BITS-1:0]      prefix;
    logic [COUNT_BITS-1:0]    run_count;
    logic [SUM_BITS-1:0]      slot_keys   [TABLE_SLOTS];
    logic [SLOT_CNT_BITS-1:0] slot_counts [TABLE_SLOTS];
    bit                       slot_live   [TABLE_SLOTS];
    bit                       overflow;
    count_result_t            counts_due[$];
    int                       mismatches;
    int                       values_seen;
    int                       results_seen;
    int                       runs_closed;
    int                       full_seen;
    int                       sat_seen;

    function new();
      target       = '0;
      mismatches   = 0;
      values_seen  = 0;
      results_seen = 0;
      runs_closed  = 0;
      full_seen    = 0;
      sat_seen     = 0;
      restart();
    endfunction

    // Slot holding key, else first free slot on its probe path, else TABLE_SLOTS
    function int find_slot(logic [SUM_BITS-1:0] k, output bit hit);
      logic [SUM_BITS-1:0] h;
      int                  idx;
      h   = k * sscpt_pkg::HASH_MULT;
      idx = int'(h % 32'(TABLE_SLOTS));
      hit = 1'b0;
      for (int n = 0; n < TABLE_SLOTS; n++) begin
        if (!slot_live[idx]) return idx;
        if (slot_keys[idx] == k) begin
          hit = 1'b1;
          return idx;
        end
        idx = (idx + 1) % TABLE_SLOTS;
      end
      return TABLE_SLOTS;
    endfunction

    // Start of a sequence: empty table plus the zero seed
    function void restart();
      bit hit;
      int idx;
      prefix    = '0;
      run_count = '0;
      overflow  = 1'b0;
      foreach (slot_live[i]) slot_live[i] = 1'b0;
      idx = find_slot('0, hit);
      slot_live[idx]   = 1'b1;
      slot_keys[idx]   = '0;
      slot_counts[idx] = 1;
    endfunction

    // Accepted input transaction: predict its result
    function void note_value(logic [VALUE_BITS-1:0] v, logic l);
      bit            hit;
      int            idx;
      int unsigned   acc;
      count_result_t want;
      values_seen++;
      prefix = prefix + SUM_BITS'(signed'(v));

      // add occurrences of (prefix - target)
      idx = find_slot(prefix - target, hit);
      if (hit) begin
        acc = run_count + slot_counts[idx];
        if (acc > sscpt_pkg::COUNT_MAX) begin
          acc = sscpt_pkg::COUNT_MAX;
          sat_seen++;
        end
        run_count = COUNT_BITS'(acc);
      end

      // record the new prefix
      idx = find_slot(prefix, hit);
      if (idx >= TABLE_SLOTS) begin
        overflow = 1'b1;
        full_seen++;
      end else if (hit) begin
        if (slot_counts[idx] < sscpt_pkg::SLOT_CNT_MAX) slot_counts[idx]++;
      end else begin
        slot_live[idx]   = 1'b1;
        slot_keys[idx]   = prefix;
        slot_counts[idx] = 1;
      end

      want.match_count = run_count;
      want.final_res   = l;
      want.table_full  = overflow;
      counts_due.push_back(want);
      if (l) begin
        runs_closed++;
        restart();
      end
    endfunction

    // Accepted output transaction: compare with the oldest expectation
    function void check_count(count_result_t got);
      count_result_t want;
      results_seen++;
      if (counts_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: match_count=%0d final_res=%0b table_full=%0b",
                   got.match_count, got.final_res, got.table_full);
        return;
      end
      want = counts_due.pop_front();
      if (got.match_count !== want.match_count || got.final_res !== want.final_res ||
          got.table_full !== want.table_full) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d mismatch: match_count exp %0d got %0d, ", results_seen,
                   want.match_count, got.match_count,
                   "final_res exp %0b got %0b, table_full exp %0b got %0b",
                   want.final_res, got.final_res, want.table_full, got.table_full);
      end
    endfunction

    function void close();
      if (counts_due.size() != 0) begin
        $display("%0d expected results never arrived", counts_due.size());
        mismatches += counts_due.size();
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Signals
  // --------------------------------------------------------------------------
  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  psel      = 1'b0;
  logic                  penable   = 1'b0;
  logic                  pwrite    = 1'b0;
  logic [2:0]            paddr     = '0;
  logic [31:0]           pwdata    = '0;
  logic [31:0]           prdata;
  logic                  pready;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  logic [VALUE_BITS-1:0] value     = '0;
  logic                  last      = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [COUNT_BITS-1:0] match_count;
  logic                  final_res;
  logic                  table_full;

  match_count_board sb = new();
  bit               tx_burst = 1'b0;
  int               idle_cycles = 0;
  int               target_writes = 0;

  subarray_sum_count_prefix_table_top uut (
    .clk, .rst,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid, .in_ready, .value, .last,
    .out_valid, .out_ready, .match_count, .final_res, .table_full
  );

  // Clock and reset
  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
  end

  // --------------------------------------------------------------------------
  // APB tasks
  // --------------------------------------------------------------------------
  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apb_read(input logic [2:0] addr, output logic [31:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    data = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_target(input logic [31:0] t);
    apb_write(ADDR_TARGET_SUM, t);
    sb.target = t;
    target_writes++;
  endtask

  // --------------------------------------------------------------------------
  // Input channel
  // --------------------------------------------------------------------------
  task automatic send_item(input logic [VALUE_BITS-1:0] v, input logic l);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 13);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    value    <= v;
    last     <= l;
    do @(posedge clk); while (!in_ready);
    sb.note_value(v, l);
  endtask

  // Stop offering and wait until every expected count has come back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.counts_due.size() != 0);
  endtask

  function automatic logic [VALUE_BITS-1:0] pick_value(value_mix_t mix);
    case (mix)
      MIX_SMALL:  return VALUE_BITS'($urandom_range(0, 8) - 4);
      MIX_FULL:   return VALUE_BITS'($urandom());
      // multiples of the table size land on the same home slot
      MIX_STRIDE: return VALUE_BITS'($urandom_range(0, 4) * TABLE_SLOTS - 2 * TABLE_SLOTS
                                     + $urandom_range(0, 2) - 1);
      default: begin
        case ($urandom_range(0, 4))
          0:       return 16'h7FFF;
          1:       return 16'h8000;
          2:       return 16'h0000;
          3:       return 16'hFFFF;
          default: return 16'h0001;
        endcase
      end
    endcase
  endfunction

  // One random sequence; a few items are full-range noise
  task automatic run_sequence(input int len, input value_mix_t mix);
    logic [VALUE_BITS-1:0] v;
    for (int i = 0; i < len; i++) begin
      v = ($urandom_range(0, 9) == 0) ? pick_value(MIX_FULL) : pick_value(mix);
      send_item(v, i == len - 1);
    end
  endtask

  // --------------------------------------------------------------------------
  // Output channel: random ready gaps, burst stretches, two long holds
  // --------------------------------------------------------------------------
  initial begin
    int            gap;
    int            rx_count;
    int            rx_left;
    bit            rx_burst;
    count_result_t got;
    rx_count = 0;
    rx_left  = 0;
    rx_burst = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (rx_left == 0) begin
        rx_left  = $urandom_range(10, 60);
        rx_burst = ($urandom_range(0, 2) == 0);
      end
      rx_left--;
      gap = rx_burst ? 0 : $urandom_range(0, 13);
      if (rx_count == 150 || rx_count == 1200) gap = LONG_HOLD;
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      got.match_count = match_count;
      got.final_res   = final_res;
      got.table_full  = table_full;
      sb.check_count(got);
      rx_count++;
    end
  end

  // Watchdog: ends the run when no transaction moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
        $display("FAIL");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    logic [31:0] rd;
    logic [31:0] t;
    int          phase_items;
    int          len;
    int          r;
    @(posedge clk);
    while (rst) @(posedge clk);

    // Directed: reset target of zero, field extremes, single-item sequence
    send_item(16'h0000, 1'b0);
    send_item(16'h7FFF, 1'b0);
    send_item(16'h8000, 1'b0);
    send_item(16'h0001, 1'b1);
    send_item(16'h0000, 1'b1);
    drain();

    // Target write, ignored register index, read back
    set_target(32'd3);
    apb_write(ADDR_UNUSED, 32'hDEAD_BEEF);
    apb_read(ADDR_TARGET_SUM, rd);
    if (rd !== sb.target) begin
      sb.mismatches++;
      $display("target_sum read back exp %0h got %0h", sb.target, rd);
    end
    send_item(16'd1, 1'b0);
    send_item(16'd2, 1'b0);
    send_item(16'd0, 1'b0);
    send_item(16'd3, 1'b0);
    send_item(-16'sd3, 1'b0);
    send_item(16'd3, 1'b1);
    drain();

    // Extreme targets
    set_target(32'h8000_0000);
    send_item(16'h8000, 1'b0);
    send_item(16'h8000, 1'b1);
    drain();
    set_target(32'h7FFF_FFFF);
    send_item(16'h7FFF, 1'b1);
    drain();

    // Keys a table size apart share a home slot: probe chains
    set_target(32'd2048);
    send_item(16'd2048, 1'b0);
    send_item(16'd2048, 1'b0);
    send_item(16'hF000, 1'b0);
    send_item(16'd4096, 1'b0);
    send_item(16'd0, 1'b1);
    drain();

    // Many one-item sequences: the table restarts and is swept clean again
    set_target(32'd0);
    for (int i = 0; i < 260; i++) begin
      send_item(pick_value(value_mix_t'($urandom_range(0, 3))), 1'b1);
    end
    drain();

    // Random phases, one target setting each
    for (int p = 0; p < 8; p++) begin
      case (p)
        0:       t = 32'd0;
        1:       t = 32'd1;
        2:       t = 32'hFFFF_FFFF;
        3:       t = 32'd2048;
        4:       t = 32'h7FFF_FFFF;
        5:       t = 32'h8000_0000;
        6:       t = 32'($urandom_range(0, 40)) - 32'd20;
        default: t = $urandom();
      endcase
      set_target(t);
      phase_items = 0;
      while (phase_items < 40) begin
        r   = $urandom_range(0, 99);
        len = (r < 80) ? $urandom_range(1, 12) :
              (r < 95) ? $urandom_range(13, 40) : $urandom_range(41, 100);
        tx_burst = ($urandom_range(0, 3) == 0);
        run_sequence(len, value_mix_t'($urandom_range(0, 3)));
        phase_items += len;
      end
      drain();
    end

    // Long all-zero run: the running count saturates near its end
    set_target(32'd0);
    tx_burst = 1'b0;
    for (int i = 0; i < 1460; i++) send_item(16'd0, i == 1459);
    drain();

    repeat (TAIL_CYCLES) @(posedge clk);
    sb.close();
    $display("covered %0d values in %0d sequences, %0d results, %0d target writes",
             sb.values_seen, sb.runs_closed, sb.results_seen, target_writes);
    $display("saturating adds %0d, items with table full %0d, mismatches %0d",
             sb.sat_seen, sb.full_seen, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
